/* sv/taabb_pkg.sv */
`timescale 1ns / 1ps

package taabb_pkg;

  localparam int COEF_BITS = 16;
  localparam int ROW_BITS  = 3 * COEF_BITS;
  localparam int AXES      = 3;

  // Register loads for the four pipeline stages, driven by the top-level control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_load_t;

endpackage

/* sv/taabb_axis.sv */
`timescale 1ns / 1ps

module taabb_axis #(
  parameter int COORD_BITS     = 32,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  taabb_pkg::stage_load_t              load,
  input  logic signed [COORD_BITS-1:0]        lo [taabb_pkg::AXES],
  input  logic signed [COORD_BITS-1:0]        hi [taabb_pkg::AXES],
  input  logic        [taabb_pkg::ROW_BITS-1:0] row,
  input  logic signed [COORD_BITS-1:0]        shift,
  output logic signed [COORD_BITS-1:0]        world_min,
  output logic signed [COORD_BITS-1:0]        world_max
);
  import taabb_pkg::*;

  localparam int PW = COORD_BITS + COEF_BITS;
  localparam int TW = PW - COEF_FRAC_BITS;
  localparam int SW = TW + 2;

  logic signed [PW-1:0]         prod_lo [AXES];
  logic signed [PW-1:0]         prod_hi [AXES];
  logic signed [TW-1:0]         term_a  [AXES];
  logic signed [TW-1:0]         term_b  [AXES];
  logic signed [TW-1:0]         term_mn [AXES];
  logic signed [TW-1:0]         term_mx [AXES];
  logic signed [COORD_BITS-1:0] shift_d1;
  logic signed [COORD_BITS-1:0] shift_d2;
  logic signed [SW-1:0]         sum_mn_next;
  logic signed [SW-1:0]         sum_mx_next;
  logic signed [SW-1:0]         sum_mn;
  logic signed [SW-1:0]         sum_mx;

  function automatic logic [COORD_BITS-1:0] saturate(input logic [SW-1:0] v);
    logic [SW-COORD_BITS:0] top;
    top = v[SW-1:COORD_BITS-1];
    if (&top || ~|top) begin
      return v[COORD_BITS-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      prod_lo[j] = $signed(row[COEF_BITS*j +: COEF_BITS]) * lo[j];
      prod_hi[j] = $signed(row[COEF_BITS*j +: COEF_BITS]) * hi[j];
    end
  end

  // Stage 1: products, floor-truncated by dropping the low fraction bits
  always_ff @(posedge clk) begin
    if (load.s1) begin
      for (int j = 0; j < AXES; j++) begin
        term_a[j] <= prod_lo[j][PW-1:COEF_FRAC_BITS];
        term_b[j] <= prod_hi[j][PW-1:COEF_FRAC_BITS];
      end
      shift_d1 <= shift;
    end
  end

  // Stage 2: order each term pair
  always_ff @(posedge clk) begin
    if (load.s2) begin
      for (int j = 0; j < AXES; j++) begin
        term_mn[j] <= (term_a[j] < term_b[j]) ? term_a[j] : term_b[j];
        term_mx[j] <= (term_a[j] < term_b[j]) ? term_b[j] : term_a[j];
      end
      shift_d2 <= shift_d1;
    end
  end

  always_comb begin
    sum_mn_next = SW'(shift_d2) + SW'(term_mn[0]) + SW'(term_mn[1]) + SW'(term_mn[2]);
    sum_mx_next = SW'(shift_d2) + SW'(term_mx[0]) + SW'(term_mx[1]) + SW'(term_mx[2]);
  end

  // Stage 3: exact sums
  always_ff @(posedge clk) begin
    if (load.s3) begin
      sum_mn <= sum_mn_next;
      sum_mx <= sum_mx_next;
    end
  end

  // Stage 4: clamp into the output register
  always_ff @(posedge clk) begin
    if (load.s4) begin
      world_min <= saturate(sum_mn);
      world_max <= saturate(sum_mx);
    end
  end

endmodule

/* sv/transform_aabb.sv */
`timescale 1ns / 1ps
// A request moves through the four stages (multiply, order, sum, clamp) to the
// outputs. Throughput: one box per cycle while out_ready is high; the stages
// each hold one request and advance whenever the stage after them frees up.
// Reset clears the stage valid bits only; the pipeline is empty after reset.

module transform_aabb #(
  parameter int COORD_BITS     = 32,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       box_min_x,
  input  logic signed [COORD_BITS-1:0]       box_min_y,
  input  logic signed [COORD_BITS-1:0]       box_min_z,
  input  logic signed [COORD_BITS-1:0]       box_max_x,
  input  logic signed [COORD_BITS-1:0]       box_max_y,
  input  logic signed [COORD_BITS-1:0]       box_max_z,
  input  logic [taabb_pkg::ROW_BITS-1:0]     row_x_linear,
  input  logic [taabb_pkg::ROW_BITS-1:0]     row_y_linear,
  input  logic [taabb_pkg::ROW_BITS-1:0]     row_z_linear,
  input  logic signed [COORD_BITS-1:0]       shift_x,
  input  logic signed [COORD_BITS-1:0]       shift_y,
  input  logic signed [COORD_BITS-1:0]       shift_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_BITS-1:0]       world_min_x,
  output logic signed [COORD_BITS-1:0]       world_min_y,
  output logic signed [COORD_BITS-1:0]       world_min_z,
  output logic signed [COORD_BITS-1:0]       world_max_x,
  output logic signed [COORD_BITS-1:0]       world_max_y,
  output logic signed [COORD_BITS-1:0]       world_max_z
);
  import taabb_pkg::*;

  logic [3:0]                   stage_valid;
  logic [3:0]                   free;
  stage_load_t                  load;
  logic signed [COORD_BITS-1:0] lo [AXES];
  logic signed [COORD_BITS-1:0] hi [AXES];

  // A stage can take a request when empty or when its request moves on
  always_comb begin
    free[3] = !stage_valid[3] || out_ready;
    free[2] = !stage_valid[2] || free[3];
    free[1] = !stage_valid[1] || free[2];
    free[0] = !stage_valid[0] || free[1];
    load.s1 = in_valid && free[0];
    load.s2 = stage_valid[0] && free[1];
    load.s3 = stage_valid[1] && free[2];
    load.s4 = stage_valid[2] && free[3];
  end

  assign in_ready  = free[0];
  assign out_valid = stage_valid[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (free[0]) stage_valid[0] <= in_valid;
      if (free[1]) stage_valid[1] <= stage_valid[0];
      if (free[2]) stage_valid[2] <= stage_valid[1];
      if (free[3]) stage_valid[3] <= stage_valid[2];
    end
  end

  assign lo[0] = box_min_x;
  assign lo[1] = box_min_y;
  assign lo[2] = box_min_z;
  assign hi[0] = box_max_x;
  assign hi[1] = box_max_y;
  assign hi[2] = box_max_z;

  taabb_axis #(
    .COORD_BITS    (COORD_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_axis_x (
    .clk      (clk),
    .load     (load),
    .lo       (lo),
    .hi       (hi),
    .row      (row_x_linear),
    .shift    (shift_x),
    .world_min(world_min_x),
    .world_max(world_max_x)
  );

  taabb_axis #(
    .COORD_BITS    (COORD_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_axis_y (
    .clk      (clk),
    .load     (load),
    .lo       (lo),
    .hi       (hi),
    .row      (row_y_linear),
    .shift    (shift_y),
    .world_min(world_min_y),
    .world_max(world_max_y)
  );

  taabb_axis #(
    .COORD_BITS    (COORD_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_axis_z (
    .clk      (clk),
    .load     (load),
    .lo       (lo),
    .hi       (hi),
    .row      (row_z_linear),
    .shift    (shift_z),
    .world_min(world_min_z),
    .world_max(world_max_z)
  );

endmodule

/* tb/sv/aabb_hull_checker.sv */
`timescale 1ns / 1ps

module aabb_hull_checker #(
  parameter int FRAC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [31:0]            box_min_x,
  input  logic signed [31:0]            box_min_y,
  input  logic signed [31:0]            box_min_z,
  input  logic signed [31:0]            box_max_x,
  input  logic signed [31:0]            box_max_y,
  input  logic signed [31:0]            box_max_z,
  input  logic [taabb_pkg::ROW_BITS-1:0] row_x_linear,
  input  logic [taabb_pkg::ROW_BITS-1:0] row_y_linear,
  input  logic [taabb_pkg::ROW_BITS-1:0] row_z_linear,
  input  logic signed [31:0]            shift_x,
  input  logic signed [31:0]            shift_y,
  input  logic signed [31:0]            shift_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [31:0]            world_min_x,
  input  logic signed [31:0]            world_min_y,
  input  logic signed [31:0]            world_min_z,
  input  logic signed [31:0]            world_max_x,
  input  logic signed [31:0]            world_max_y,
  input  logic signed [31:0]            world_max_z,
  output int                            mismatches,
  output int                            outstanding
);

  import taabb_pkg::*;

  localparam longint COORD_MAX = (longint'(1) <<< 31) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // index 0..2 hold the minimum x, y, z; 3..5 the maximum x, y, z
  typedef logic [5:0][31:0] world_box_t;

  world_box_t hulls_due[$];
  int         fail_count = 0;
  string      field_name [6] = '{"world_min_x", "world_min_y", "world_min_z",
                                 "world_max_x", "world_max_y", "world_max_z"};

  assign mismatches = fail_count;

  function automatic logic [31:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return 32'h7FFF_FFFF;
    if (v < COORD_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Each term depends on one coordinate only, so take its own min and max
  // over the two corner values; the sums then give the eight-corner hull.
  function automatic world_box_t hull_of(input logic [2:0][31:0] lo_c,
                                         input logic [2:0][31:0] hi_c,
                                         input logic [2:0][31:0] shift,
                                         input logic [2:0][ROW_BITS-1:0] rows);
    world_box_t         hull;
    longint             acc_lo, acc_hi, t_a, t_b;
    logic signed [15:0] coef;
    int                 a, k;
    for (a = 0; a < AXES; a++) begin
      acc_lo = longint'($signed(shift[a]));
      acc_hi = acc_lo;
      for (k = 0; k < AXES; k++) begin
        coef = rows[a][k*COEF_BITS +: COEF_BITS];
        // arithmetic shift of a signed product floors toward minus infinity
        t_a = (longint'(coef) * longint'($signed(lo_c[k]))) >>> FRAC_BITS;
        t_b = (longint'(coef) * longint'($signed(hi_c[k]))) >>> FRAC_BITS;
        if (t_a < t_b) begin
          acc_lo += t_a;
          acc_hi += t_b;
        end else begin
          acc_lo += t_b;
          acc_hi += t_a;
        end
      end
      hull[a]     = clamp_coord(acc_lo);
      hull[a + 3] = clamp_coord(acc_hi);
    end
    return hull;
  endfunction

  always @(posedge clk) begin : watch
    world_box_t got, want;
    int         k;
    if (rst) begin
      hulls_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {world_max_z, world_max_y, world_max_x,
               world_min_z, world_min_y, world_min_x};
        if (hulls_due.size() == 0) begin
          $display("%0t: result with no request waiting, expected none got %h",
                   $time, got);
          fail_count++;
        end else begin
          want = hulls_due.pop_front();
          for (k = 0; k < 6; k++) begin
            if (got[k] !== want[k]) begin
              $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, field_name[k],
                       $signed(want[k]), want[k], $signed(got[k]), got[k]);
              fail_count++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        hulls_due.push_back(hull_of({box_min_z, box_min_y, box_min_x},
                                    {box_max_z, box_max_y, box_max_x},
                                    {shift_z, shift_y, shift_x},
                                    {row_z_linear, row_y_linear, row_x_linear}));
      end
    end
    outstanding <= hulls_due.size();
  end

endmodule

/* tb/sv/tb_transform_aabb.sv */
`timescale 1ns / 1ps

module tb_transform_aabb;

  import taabb_pkg::*;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int CALM_TAIL       = 150;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic [2:0][31:0]         lo;
    logic [2:0][31:0]         hi;
    logic [2:0][31:0]         shift;
    logic [2:0][ROW_BITS-1:0] rows;
  } box_req_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;

  logic signed [31:0]   box_min_x = '0, box_min_y = '0, box_min_z = '0;
  logic signed [31:0]   box_max_x = '0, box_max_y = '0, box_max_z = '0;
  logic [ROW_BITS-1:0]  row_x_linear = '0, row_y_linear = '0, row_z_linear = '0;
  logic signed [31:0]   shift_x = '0, shift_y = '0, shift_z = '0;
  logic signed [31:0]   world_min_x, world_min_y, world_min_z;
  logic signed [31:0]   world_max_x, world_max_y, world_max_z;

  int   mismatches, outstanding;
  logic req_taken   = 1'b0;
  bit   idle_on     = 1'b1;
  int   idle_pct    = 25;
  int   stall_left  = 0;
  int   cycle_count = 0;

  transform_aabb dut (.*);

  aabb_hull_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // seen by the driver at the following falling edge
  always @(posedge clk) req_taken <= !rst && in_valid && in_ready;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9)) inside
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      [1:3]:   return $urandom;
      default: return $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    logic [31:0] v;
    case ($urandom_range(0, 9)) inside
      [0:1]: begin
        case ($urandom_range(0, 6))
          0:       v = 32'h7FFF;
          1:       v = 32'h8000;
          2:       v = 32'h0000;
          3:       v = 32'h1000;
          4:       v = 32'hF000;
          5:       v = 32'hFFFF;
          default: v = 32'h0001;
        endcase
      end
      [2:4]: v = $urandom;
      // within +/-4.0, the usual span of a rotation and scale
      default: v = $urandom_range(0, 32768) - 16384;
    endcase
    return v[15:0];
  endfunction

  function automatic box_req_t rand_request();
    box_req_t    r;
    logic [31:0] held;
    int          a;
    for (a = 0; a < AXES; a++) begin
      r.lo[a] = rand_coord();
      r.hi[a] = rand_coord();
      // mostly ordered corners; the rest stay inverted as drawn
      if ($urandom_range(0, 9) < 7 && $signed(r.lo[a]) > $signed(r.hi[a])) begin
        held    = r.lo[a];
        r.lo[a] = r.hi[a];
        r.hi[a] = held;
      end
      r.shift[a] = rand_coord();
      r.rows[a]  = {rand_coef(), rand_coef(), rand_coef()};
    end
    return r;
  endfunction

  function automatic box_req_t uniform_request(input logic [31:0] lo_v, hi_v, shift_v,
                                               input logic [ROW_BITS-1:0] row_v);
    box_req_t r;
    r.lo    = {3{lo_v}};
    r.hi    = {3{hi_v}};
    r.shift = {3{shift_v}};
    r.rows  = {3{row_v}};
    return r;
  endfunction

  // call at a falling edge; returns at a falling edge once the request is taken
  task automatic send_request(input box_req_t r);
    {box_min_z, box_min_y, box_min_x}          = r.lo;
    {box_max_z, box_max_y, box_max_x}          = r.hi;
    {shift_z, shift_y, shift_x}                = r.shift;
    {row_z_linear, row_y_linear, row_x_linear} = r.rows;
    in_valid = 1'b1;
    do @(negedge clk); while (!req_taken);
    if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    box_req_t r;
    int       n;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(uniform_request(32'h0, 32'h0, 32'h0, 48'h0));

    // identity, then identity with a translation
    r = uniform_request(32'hFFFF_0000, 32'h0002_0000, 32'h0, 48'h0);
    r.rows = {48'h1000_0000_0000, 48'h0000_1000_0000, 48'h0000_0000_1000};
    send_request(r);
    r.shift = {32'h0000_8000, 32'hFFF0_0000, 32'h0010_0000};
    send_request(r);

    // swizzle with a negative and a fractional scale
    r.lo   = {32'hFFFE_8000, 32'h0000_4000, 32'hFFFF_FFFF};
    r.hi   = {32'h0003_0000, 32'h0001_0000, 32'h0000_0001};
    r.rows = {48'h0000_0000_0800, 48'h2000_0000_0000, 48'h0000_F000_0000};
    send_request(r);

    // full-range corners against the largest coefficients, saturating both ways
    send_request(uniform_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 48'h7FFF_7FFF_7FFF));
    send_request(uniform_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 48'h8000_8000_8000));
    send_request(uniform_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 48'h8000_8000_8000));
    send_request(uniform_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                 48'h7FFF_7FFF_7FFF));
    send_request(uniform_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 48'h7FFF_7FFF_7FFF));
    send_request(uniform_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 48'h7FFF_7FFF_7FFF));

    // translation alone at both bounds
    send_request(uniform_request(32'h0, 32'h0, 32'h7FFF_FFFF, 48'h0));
    send_request(uniform_request(32'h0, 32'h0, 32'h8000_0000, 48'h0));

    // products below one LSB: negative ones floor to -1, positive ones to 0
    send_request(uniform_request(32'h1, 32'h1, 32'h0, 48'hFFFF_FFFF_FFFF));
    send_request(uniform_request(32'hFFFF_FFFF, 32'h1, 32'h0, 48'h0001_0001_0001));
    send_request(uniform_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 48'hFFFF_FFFF_FFFF));

    // inverted boxes
    send_request(uniform_request(32'h0005_0000, 32'hFFFD_0000, 32'h0, 48'h1000_F000_1000));
    send_request(uniform_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000,
                                 48'h7FFF_8000_0001));

    // sum just past the top bound with in-range terms
    send_request(uniform_request(32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                                 48'h0000_0000_1000));

    send_request(uniform_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                                 48'hAAAA_5555_AAAA));
    send_request(uniform_request(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                 48'h5555_AAAA_5555));

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 200 == 0) begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 30;
          default: idle_pct = 60;
        endcase
      end
      // run the tail at full rate on both sides
      if (n == RANDOM_REQUESTS - CALM_TAIL) idle_on = 1'b0;
      send_request(rand_request());
    end
    in_valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/taabb_pkg.sv
sv/taabb_axis.sv
sv/transform_aabb.sv
tb/sv/aabb_hull_checker.sv
tb/sv/tb_transform_aabb.sv
